// ===== hdl/page_frame_free_list_allocator_unit_assert.svh =====
// Assertion macros for the page frame allocator RTL, used by its top unit.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`define PFA_ASSERT_TWO(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== hdl/pffla_pkg.sv =====
// Types and constants of the page frame free list allocator.
package pffla_pkg;

    localparam int PAGE_W  = 12;
    localparam int SIZE_W  = 13;
    localparam int CFG_W   = 13;
    localparam int MODE_W  = 3;
    localparam int PAGE_SPAN = 4096;

    localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_LOW = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE_LOW  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TAKE      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RETURN    = 3'd5;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_BAD   = 2'd2;

    localparam logic [1:0] LIST_FREE = 2'd0;
    localparam logic [1:0] LIST_LOW  = 2'd1;
    localparam logic [1:0] LIST_ZERO = 2'd2;

    localparam logic CFG_PAGE_COUNT = 1'b0;
    localparam logic CFG_LOW_LIMIT  = 1'b1;

    localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 13'd4096;
    localparam logic [CFG_W-1:0] LOW_LIMIT_RST  = 13'd256;

    typedef enum logic [1:0] {
        FS_ALLOCATED = 2'd0,
        FS_FREE      = 2'd1,
        FS_LOW       = 2'd2,
        FS_ZERO      = 2'd3
    } t_frame;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page_in;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0] page_out;
        logic [1:0]        status;
        logic              needs_clearing;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_stat;

endpackage

// ===== hdl/pffla_ctrl.sv =====
// Sequencer of the page frame allocator: clearing pass, accept and execute.
module pffla_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  pffla_pkg::t_stat i_stat,
    output pffla_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import pffla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/pffla_datapath.sv =====
// List registers, link and frame state memories and result register.
module pffla_datapath #(
    parameter int MAX_PAGES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pffla_pkg::t_cmd               i_cmd,
    output pffla_pkg::t_stat              o_stat,
    input  pffla_pkg::t_req               i_req,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [pffla_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                          o_done,
    output pffla_pkg::t_rsp               o_rsp
);
    import pffla_pkg::*;

    // Page numbers are 12 bits wide, so frames beyond that span are never addressed.
    localparam int DEPTH = (MAX_PAGES < PAGE_SPAN) ? MAX_PAGES : PAGE_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CFG_W-1:0] DEPTH_LIM = CFG_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

    logic [PAGE_W-1:0] mem_link [DEPTH];
    t_frame            mem_fs   [DEPTH];

    logic [CFG_W-1:0]  r_page_count;
    logic [CFG_W-1:0]  r_low_limit;
    logic [PAGE_W-1:0] r_head [3];
    logic [PAGE_W-1:0] r_tail [3];
    logic [SIZE_W-1:0] r_size [3];
    logic [PAGE_W-1:0] n_head [3];
    logic [PAGE_W-1:0] n_tail [3];
    logic [SIZE_W-1:0] n_size [3];
    logic [AW-1:0]     r_clr_addr;
    logic [MODE_W-1:0] r_mode;
    logic [PAGE_W-1:0] r_page;
    logic [1:0]        r_sel;
    logic [PAGE_W-1:0] r_link_rd;
    t_frame            r_fs_rd;
    logic              r_done;
    t_rsp              r_rsp;

    logic [1:0]        n_sel;
    logic [PAGE_W-1:0] cur_head;
    logic [PAGE_W-1:0] cur_tail;
    logic [SIZE_W-1:0] cur_size;
    logic              is_take;
    logic              is_app;
    logic              take_ok;
    logic              app_ok;
    logic              in_range;
    logic              region_ok;
    logic [CFG_W-1:0]  page_ext;
    t_rsp              n_rsp;
    logic              fs_we;
    logic [AW-1:0]     fs_wa;
    t_frame            fs_wd;
    t_frame            app_state;
    logic              link_we;

    // List choice is made when the transaction is accepted, so the head
    // address can go to the link memory in the same cycle.
    always_comb begin
        n_sel = LIST_FREE;
        unique case (i_req.mode) inside
            MODE_ALLOC: begin
                n_sel = (r_size[LIST_ZERO] != '0) ? LIST_ZERO : LIST_FREE;
            end
            MODE_ALLOC_LOW, MODE_FREE_LOW: begin
                n_sel = LIST_LOW;
            end
            MODE_RETURN: begin
                n_sel = LIST_ZERO;
            end
            default: begin
                n_sel = LIST_FREE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_req.mode;
            r_page    <= i_req.page_in;
            r_sel     <= n_sel;
            r_link_rd <= mem_link[r_head[n_sel][AW-1:0]];
            r_fs_rd   <= mem_fs[i_req.page_in[AW-1:0]];
        end
    end

    assign cur_head = r_head[r_sel];
    assign cur_tail = r_tail[r_sel];
    assign cur_size = r_size[r_sel];
    assign page_ext = {1'b0, r_page};

    assign is_take = (r_mode == MODE_ALLOC) || (r_mode == MODE_ALLOC_LOW)
                  || (r_mode == MODE_TAKE);
    assign is_app  = (r_mode == MODE_FREE) || (r_mode == MODE_FREE_LOW)
                  || (r_mode == MODE_RETURN);
    assign in_range = (page_ext < r_page_count) && (page_ext < DEPTH_LIM);

    always_comb begin
        region_ok = 1'b1;
        case (r_mode)
            MODE_FREE:     region_ok = (page_ext >= r_low_limit);
            MODE_FREE_LOW: region_ok = (page_ext < r_low_limit);
            default:       region_ok = 1'b1;
        endcase
    end

    assign take_ok = is_take && (cur_size != '0);
    assign app_ok  = is_app && in_range && region_ok && (r_fs_rd == FS_ALLOCATED);

    always_comb begin
        n_rsp.page_out       = take_ok ? cur_head : '0;
        n_rsp.needs_clearing = take_ok && (r_mode == MODE_ALLOC) && (r_sel == LIST_FREE);
        if (take_ok || app_ok) begin
            n_rsp.status = STAT_OK;
        end else if (is_take) begin
            n_rsp.status = STAT_EMPTY;
        end else begin
            n_rsp.status = STAT_BAD;
        end
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_size = r_size;
        if (i_cmd.exec && take_ok) begin
            if (cur_size > SIZE_W'(1)) begin
                n_head[r_sel] = r_link_rd;
            end
            n_size[r_sel] = cur_size - SIZE_W'(1);
        end
        if (i_cmd.exec && app_ok) begin
            if (cur_size == '0) begin
                n_head[r_sel] = r_page;
            end
            n_tail[r_sel] = r_page;
            n_size[r_sel] = cur_size + SIZE_W'(1);
        end
    end

    always_comb begin
        case (r_sel)
            LIST_LOW:  app_state = FS_LOW;
            LIST_ZERO: app_state = FS_ZERO;
            default:   app_state = FS_FREE;
        endcase
    end

    always_comb begin
        fs_we = 1'b0;
        fs_wa = r_clr_addr;
        fs_wd = FS_ALLOCATED;
        if (i_cmd.clear) begin
            fs_we = 1'b1;
        end else if (i_cmd.exec && take_ok) begin
            fs_we = 1'b1;
            fs_wa = cur_head[AW-1:0];
        end else if (i_cmd.exec && app_ok) begin
            fs_we = 1'b1;
            fs_wa = r_page[AW-1:0];
            fs_wd = app_state;
        end
    end

    assign link_we = i_cmd.exec && app_ok && (cur_size != '0);

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            mem_fs[fs_wa] <= fs_wd;
        end
        if (link_we) begin
            mem_link[cur_tail[AW-1:0]] <= r_page;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == LAST_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= PAGE_COUNT_RST;
            r_low_limit  <= LOW_LIMIT_RST;
            r_head       <= '{default: '0};
            r_tail       <= '{default: '0};
            r_size       <= '{default: '0};
            r_clr_addr   <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PAGE_COUNT: r_page_count <= i_cfg_data;
                    CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_head <= n_head;
            r_tail <= n_tail;
            r_size <= n_size;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_done <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== hdl/page_frame_free_list_allocator_unit.sv =====
// A transaction is accepted in the idle state, reading the link memory, then runs in
// the execute state, which writes it; a new one is taken only when the block is idle.
// The receiver cannot stall; each result is shown for one cycle with o_done.
// Reset: synchronous, active low; busy after reset while the frame state memory
// (min(MAX_PAGES, 4096) entries) is swept to allocated; configuration writes are taken.
module page_frame_free_list_allocator_unit #(
    parameter int MAX_PAGES = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  pffla_pkg::t_req              i_req,
    output logic                         o_done,
    output pffla_pkg::t_rsp              o_rsp,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [pffla_pkg::CFG_W-1:0]  i_cfg_data
);
    import pffla_pkg::*;

    `include "page_frame_free_list_allocator_unit_assert.svh"

    t_cmd  cmd;
    t_stat stat;

    pffla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pffla_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

    `PFA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done, "accept not followed by execute")
    `PFA_ASSERT_TWO(a_accept_done, i_clk, i_rst_n, start && !busy, o_done, "result not strobed two cycles after accept")
    `PFA_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy, "result strobed while busy")
    `PFA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_done && (o_rsp.status != STAT_OK), (o_rsp.page_out == '0) && !o_rsp.needs_clearing, "error result carries a page")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the page frame free list allocator unit.
`timescale 1ns / 100ps
module testbench;
    import pffla_pkg::*;

    // Mode codes that the package leaves unnamed; the block must reject them.
    localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    localparam int RESET_CYCLES     = 11;
    localparam int STALL_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 8;
    localparam int REPORT_LIMIT     = 10;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int PHASES           = 8;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    t_req             i_req      = '0;
    logic             o_done;
    t_rsp             o_rsp;
    logic             i_cfg_we   = 1'b0;
    logic             i_cfg_idx  = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    page_frame_free_list_allocator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the allocator state.
    logic [PAGE_W-1:0] link_of [PAGE_SPAN];
    t_frame            frame_of [PAGE_SPAN];
    logic [PAGE_W-1:0] head_of [3];
    logic [PAGE_W-1:0] tail_of [3];
    logic [SIZE_W-1:0] size_of [3];
    logic [CFG_W-1:0]  page_limit;
    logic [CFG_W-1:0]  low_boundary;

    t_rsp expected_rsp [$];
    int   error_count = 0;
    int   stall_cycles = 0;

    typedef struct {
        bit               is_cfg;
        logic             cfg_idx;
        logic [CFG_W-1:0] cfg_val;
        t_req             req;
        bit               typed;
        t_rsp             rsp;
    } t_row;

    t_row directed_rows [$];

    int unsigned phase_pages [PHASES] = '{4096, 64, 1, 1, 4096, 4096, 2000, 300};
    int unsigned phase_low   [PHASES] = '{256, 32, 0, 1, 4096, 0, 1000, 150};
    int unsigned phase_idle  [PHASES] = '{0, 62, 17, 0, 62, 17, 62, 0};

    function automatic bit pop_head(input logic [1:0] lst, output logic [PAGE_W-1:0] pg);
        pg = head_of[lst];
        if (size_of[lst] == 0)
            return 1'b0;
        if (size_of[lst] > 1)
            head_of[lst] = link_of[pg];
        size_of[lst]--;
        frame_of[pg] = FS_ALLOCATED;
        return 1'b1;
    endfunction

    function automatic void push_tail(input logic [1:0] lst, input logic [PAGE_W-1:0] pg,
                                      input t_frame st);
        if (size_of[lst] == 0)
            head_of[lst] = pg;
        else
            link_of[tail_of[lst]] = pg;
        tail_of[lst] = pg;
        size_of[lst]++;
        frame_of[pg] = st;
    endfunction

    // Applies one transaction to the shadow state and returns the result it must give.
    function automatic t_rsp predict_alloc(input t_req r);
        t_rsp              rsp;
        logic [PAGE_W-1:0] pg;
        bit                in_range;
        bit                below;
        rsp      = '0;
        in_range = {1'b0, r.page_in} < page_limit;
        below    = {1'b0, r.page_in} < low_boundary;
        case (r.mode)
            MODE_ALLOC: begin
                if (pop_head(LIST_ZERO, pg)) begin
                    rsp.page_out = pg;
                end else if (pop_head(LIST_FREE, pg)) begin
                    rsp.page_out       = pg;
                    rsp.needs_clearing = 1'b1;
                end else begin
                    rsp.status = STAT_EMPTY;
                end
            end
            MODE_ALLOC_LOW: begin
                if (pop_head(LIST_LOW, pg))
                    rsp.page_out = pg;
                else
                    rsp.status = STAT_EMPTY;
            end
            MODE_TAKE: begin
                if (pop_head(LIST_FREE, pg))
                    rsp.page_out = pg;
                else
                    rsp.status = STAT_EMPTY;
            end
            MODE_FREE: begin
                if (!in_range || below || frame_of[r.page_in] != FS_ALLOCATED)
                    rsp.status = STAT_BAD;
                else
                    push_tail(LIST_FREE, r.page_in, FS_FREE);
            end
            MODE_FREE_LOW: begin
                if (!in_range || !below || frame_of[r.page_in] != FS_ALLOCATED)
                    rsp.status = STAT_BAD;
                else
                    push_tail(LIST_LOW, r.page_in, FS_LOW);
            end
            MODE_RETURN: begin
                if (!in_range || frame_of[r.page_in] != FS_ALLOCATED)
                    rsp.status = STAT_BAD;
                else
                    push_tail(LIST_ZERO, r.page_in, FS_ZERO);
            end
            default: rsp.status = STAT_BAD;
        endcase
        return rsp;
    endfunction

    function automatic void add_txn(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] pg,
                                    input bit typed, input logic [PAGE_W-1:0] page_out,
                                    input logic [1:0] status, input logic clr);
        t_row row;
        row               = '{default: '0};
        row.req.mode      = mode;
        row.req.page_in   = pg;
        row.typed         = typed;
        row.rsp.page_out  = page_out;
        row.rsp.status    = status;
        row.rsp.needs_clearing = clr;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic idx, input logic [CFG_W-1:0] val);
        t_row row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        directed_rows.push_back(row);
    endfunction

    // Random transaction: pages cluster around the low boundary so that lists fill,
    // drain and see double frees; some land at the page count edge or anywhere.
    function automatic t_req pick_req();
        t_req r;
        int   roll;
        int   pg;
        roll = int'($urandom_range(0, 99));
        if (roll < 22)      r.mode = MODE_ALLOC;
        else if (roll < 38) r.mode = MODE_ALLOC_LOW;
        else if (roll < 60) r.mode = MODE_FREE;
        else if (roll < 76) r.mode = MODE_FREE_LOW;
        else if (roll < 86) r.mode = MODE_TAKE;
        else if (roll < 97) r.mode = MODE_RETURN;
        else if (roll < 99) r.mode = MODE_UNUSED_6;
        else                r.mode = MODE_UNUSED_7;
        roll = int'($urandom_range(0, 99));
        if (roll < 65)
            pg = int'(low_boundary) + int'($urandom_range(0, 47)) - 24;
        else if (roll < 80)
            pg = int'(page_limit) + int'($urandom_range(0, 7)) - 4;
        else
            pg = int'($urandom_range(0, PAGE_SPAN - 1));
        if (pg < 0)
            pg = 0;
        if (pg > PAGE_SPAN - 1)
            pg = PAGE_SPAN - 1;
        r.page_in = pg[PAGE_W-1:0];
        return r;
    endfunction

    task automatic send_one(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp rsp;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        rsp = predict_alloc(r);
        expected_rsp.push_back(typed ? typed_rsp : rsp);
    endtask

    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_rsp.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PAGE_COUNT)
            page_limit = val;
        else
            low_boundary = val;
    endtask

    // Result checking and the stall watchdog.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_rsp.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected result: page %0d status %0d clear %0b",
                                 o_rsp.page_out, o_rsp.status, o_rsp.needs_clearing);
                end else begin
                    want = expected_rsp.pop_front();
                    if (o_rsp.page_out !== want.page_out || o_rsp.status !== want.status ||
                        o_rsp.needs_clearing !== want.needs_clearing) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("mismatch: expected page %0d status %0d clear %0b,",
                                     want.page_out, want.status, want.needs_clearing,
                                     " got page %0d status %0d clear %0b",
                                     o_rsp.page_out, o_rsp.status, o_rsp.needs_clearing);
                    end
                end
            end
            if ((start && !busy) || o_done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        t_row row;
        for (int i = 0; i < PAGE_SPAN; i++) begin
            link_of[i]  = '0;
            frame_of[i] = FS_ALLOCATED;
        end
        for (int i = 0; i < 3; i++) begin
            head_of[i] = '0;
            tail_of[i] = '0;
            size_of[i] = '0;
        end
        page_limit   = PAGE_COUNT_RST;
        low_boundary = LOW_LIMIT_RST;

        // Every list starts empty.
        add_txn(MODE_ALLOC, 12'd0, 1, 12'd0, STAT_EMPTY, 1'b0);
        add_txn(MODE_ALLOC_LOW, 12'd0, 1, 12'd0, STAT_EMPTY, 1'b0);
        add_txn(MODE_TAKE, 12'd4095, 1, 12'd0, STAT_EMPTY, 1'b0);
        add_txn(MODE_FREE, 12'd4095, 1, 12'd0, STAT_OK, 1'b0);
        // Wrong region on both sides of the low boundary.
        add_txn(MODE_FREE, 12'd0, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_FREE_LOW, 12'd0, 1, 12'd0, STAT_OK, 1'b0);
        add_txn(MODE_FREE_LOW, 12'd256, 1, 12'd0, STAT_BAD, 1'b0);
        // Double free, and returning a page that is still queued.
        add_txn(MODE_FREE, 12'd4095, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_RETURN, 12'd4095, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_RETURN, 12'd255, 1, 12'd0, STAT_OK, 1'b0);
        add_txn(MODE_FREE, 12'd300, 0, 12'd0, STAT_OK, 1'b0);
        // The zeroed list wins over the free list.
        add_txn(MODE_ALLOC, 12'd0, 1, 12'd255, STAT_OK, 1'b0);
        add_txn(MODE_ALLOC, 12'd0, 1, 12'd4095, STAT_OK, 1'b1);
        add_txn(MODE_ALLOC_LOW, 12'd0, 1, 12'd0, STAT_OK, 1'b0);
        add_txn(MODE_UNUSED_6, 12'd5, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_UNUSED_7, 12'd4095, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_TAKE, 12'd0, 0, 12'd0, STAT_OK, 1'b0);
        add_txn(MODE_ALLOC, 12'd0, 0, 12'd0, STAT_OK, 1'b0);
        // Pages at or above the page count are rejected.
        add_cfg(CFG_PAGE_COUNT, 13'd100);
        add_txn(MODE_FREE, 12'd100, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_RETURN, 12'd100, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_FREE_LOW, 12'd100, 1, 12'd0, STAT_BAD, 1'b0);
        add_txn(MODE_FREE_LOW, 12'd99, 1, 12'd0, STAT_OK, 1'b0);
        add_txn(MODE_ALLOC_LOW, 12'd0, 0, 12'd0, STAT_OK, 1'b0);
        add_cfg(CFG_PAGE_COUNT, PAGE_COUNT_RST);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                wait_drained();
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                send_one(row.req, row.typed, row.rsp);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_reg(CFG_PAGE_COUNT, CFG_W'(phase_pages[ph]));
            write_reg(CFG_LOW_LIMIT, CFG_W'(phase_low[ph]));
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                else if ($urandom_range(0, 99) < phase_idle[ph])
                    idle_for(int'($urandom_range(1, 4)));
                send_one(pick_req(), 1'b0, '0);
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
